@@ hw/rtl/csm_pkg.sv @@
// shared types and constants for the csr sparse matrix-vector core
// no dependencies
package csm_pkg;

  localparam int VEC_DEPTH     = 2048;
  localparam int ROW_COUNT_MAX = 65536;
  localparam int VEC_AW        = $clog2(VEC_DEPTH);

  localparam int CMD_W   = 2;
  localparam int INDEX_W = 11;
  localparam int VALUE_W = 32;
  localparam int SUM_W   = 64;
  localparam int ROW_W   = 16;

  localparam int IQ_DEPTH = 4;
  localparam int RQ_DEPTH = 4;
  localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TERM  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EMPTY = 2'd2;

  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROW_COUNT_MAX - 1);

  typedef enum logic [1:0] {
    OP_NOP,
    OP_LOAD,
    OP_TERM,
    OP_EMPTY
  } op_t;

  typedef struct packed {
    op_t                      op;
    logic [INDEX_W-1:0]       index;
    logic signed [VALUE_W-1:0] value;
    logic                     last;
    logic                     in_range;
  } item_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] row_sum;
    logic [ROW_W-1:0]        row_number;
  } res_t;

endpackage

@@ hw/rtl/csm_front.sv @@
// front end: accepts items, decodes the command and queues them for execution
// depends on csm_pkg
module csm_front import csm_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  output logic                      full,
  input  logic [CMD_W-1:0]          cmd,
  input  logic [INDEX_W-1:0]        index,
  input  logic signed [VALUE_W-1:0] value,
  input  logic                      last_in_row,
  input  logic                      deq,
  output logic                      head_valid,
  output item_t                     head
);

  localparam int PW = $clog2(IQ_DEPTH);
  localparam int CW = $clog2(IQ_DEPTH + 1);

  item_t          q_r [IQ_DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  item_t          dec;
  logic           accept;
  logic           enq;
  logic           do_deq;

  always_comb begin
    dec.index    = index;
    dec.value    = value;
    dec.last     = last_in_row;
    dec.in_range = (32'(index) < 32'(VEC_DEPTH));
    case (cmd)
      CMD_LOAD:  dec.op = OP_LOAD;
      CMD_TERM:  dec.op = OP_TERM;
      CMD_EMPTY: dec.op = OP_EMPTY;
      default:   dec.op = OP_NOP;
    endcase
  end

  assign full   = (cnt_r == CW'(IQ_DEPTH));
  assign accept = push && !full;
  // unused codes and loads past the store are dropped here
  assign enq    = accept && (dec.op != OP_NOP) && !(dec.op == OP_LOAD && !dec.in_range);
  assign head_valid = (cnt_r != '0);
  assign head   = q_r[rd_ptr_r];
  assign do_deq = deq && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (enq) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(IQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_deq) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(IQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({enq, do_deq})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule

@@ hw/rtl/csm_exec.sv @@
// back end: vector store, multiply and saturating row accumulate
// depends on csm_pkg
module csm_exec import csm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  item_t            q_item,
  output logic             deq,
  input  logic [RQ_CW-1:0] res_free,
  output logic             res_push,
  output res_t             res_data
);

  logic signed [VALUE_W-1:0] vec_mem [VEC_DEPTH];
  logic [VEC_AW-1:0]         addr;
  logic                      issue;

  logic                      s1_v_r;
  op_t                       s1_op_r;
  logic signed [VALUE_W-1:0] s1_value_r;
  logic                      s1_last_r;
  logic                      s1_inr_r;
  logic signed [VALUE_W-1:0] s1_x_r;
  logic signed [VALUE_W-1:0] s1_x;

  logic                      s2_v_r;
  op_t                       s2_op_r;
  logic                      s2_last_r;
  logic signed [SUM_W-1:0]   s2_prod_r;

  logic signed [SUM_W-1:0]   acc_r, acc_nxt;
  logic [ROW_W-1:0]          row_cnt_r, row_cnt_nxt;
  logic signed [SUM_W-1:0]   sum;
  logic                      ovf;
  logic signed [SUM_W-1:0]   sat_sum;

  // hold issue unless every item in flight has a result slot
  assign issue = q_valid && (res_free > (RQ_CW'(s1_v_r) + RQ_CW'(s2_v_r)));
  assign deq   = issue;
  assign addr  = VEC_AW'(q_item.index);

  always_ff @(posedge clk) begin
    if (issue && q_item.op == OP_LOAD) begin
      vec_mem[addr] <= q_item.value;
    end
    if (issue && q_item.op == OP_TERM) begin
      s1_x_r <= vec_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= issue && (q_item.op == OP_TERM || q_item.op == OP_EMPTY);
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_op_r    <= q_item.op;
    s1_value_r <= q_item.value;
    s1_last_r  <= q_item.last;
    s1_inr_r   <= q_item.in_range;
    s2_op_r    <= s1_op_r;
    s2_last_r  <= s1_last_r;
    s2_prod_r  <= s1_value_r * s1_x;
  end

  assign s1_x = s1_inr_r ? s1_x_r : '0;

  assign sum     = acc_r + s2_prod_r;
  assign ovf     = (acc_r[SUM_W-1] == s2_prod_r[SUM_W-1]) && (sum[SUM_W-1] != acc_r[SUM_W-1]);
  assign sat_sum = !ovf ? sum :
                   acc_r[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};

  always_comb begin
    acc_nxt             = acc_r;
    row_cnt_nxt         = row_cnt_r;
    res_push            = 1'b0;
    res_data.row_sum    = sat_sum;
    res_data.row_number = row_cnt_r;
    if (s2_v_r) begin
      case (s2_op_r)
        OP_TERM: begin
          acc_nxt = sat_sum;
          if (s2_last_r) begin
            res_push = 1'b1;
          end
        end
        OP_EMPTY: begin
          res_push         = 1'b1;
          res_data.row_sum = '0;
        end
        default: acc_nxt = acc_r;
      endcase
    end
    if (res_push) begin
      acc_nxt     = '0;
      row_cnt_nxt = (row_cnt_r == ROW_LAST) ? '0 : row_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      row_cnt_r <= '0;
    end else begin
      acc_r     <= acc_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (res_free != '0))
    else $error("result pushed with no free slot");

  a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |=> (acc_r == '0))
    else $error("accumulator not cleared after row");

  a_row_advances: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |=> (row_cnt_r != $past(row_cnt_r)))
    else $error("row counter did not advance");

endmodule

@@ hw/rtl/csm_result_queue.sv @@
// result queue between the execution pipeline and the output port
// depends on csm_pkg
module csm_result_queue import csm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  res_t             wr_data,
  output logic [RQ_CW-1:0] free,
  input  logic             pop,
  output logic             empty,
  output res_t             head
);

  localparam int PW = $clog2(RQ_DEPTH);

  res_t              q_r [RQ_DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [RQ_CW-1:0]  cnt_r, cnt_nxt;
  logic              do_pop;

  assign empty  = (cnt_r == '0);
  assign free   = RQ_CW'(RQ_DEPTH) - cnt_r;
  assign head   = q_r[rd_ptr_r];
  assign do_pop = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(RQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(RQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({wr_en, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

@@ hw/rtl/csr_sparse_matvec_core.sv @@
// csr sparse matrix-vector multiply core, top level
// depends on csm_pkg, csm_front, csm_exec, csm_result_queue
//
// input channel: push/full with in_cmd, in_index, in_value, in_last_in_row.
//   load items fill the vector store, term items carry the nonzeros in row
//   order, empty-row items emit a zero sum for the current row.
// result channel: empty/pop with out_row_sum (signed 64-bit, saturated) and
//   out_row_number. a result is produced by a term with last_in_row set and
//   by every empty-row item.
// throughput: one item per cycle while the result queue has room, set by
//   one store port, a 32x32 multiply and a saturating 64-bit add per cycle.
// pipeline: an issued item goes through the store read, the multiply and
//   the accumulate into the result queue, each registered.
// reset: both queues empty, accumulator and row counter zero; the vector
//   store holds nothing valid until loaded and needs no clearing pass.
// receiver stall: the 4-entry result queue fills, the pipeline stops issuing
//   once results in flight would not fit, then the 4-entry input queue fills
//   and full rises. no item is lost.
module csr_sparse_matvec_core import csm_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  output logic                      full,
  input  logic [CMD_W-1:0]          in_cmd,
  input  logic [INDEX_W-1:0]        in_index,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic                      in_last_in_row,
  output logic                      empty,
  input  logic                      pop,
  output logic signed [SUM_W-1:0]   out_row_sum,
  output logic [ROW_W-1:0]          out_row_number
);

  logic             q_valid;
  item_t            q_item;
  logic             deq;
  logic [RQ_CW-1:0] res_free;
  logic             res_push;
  res_t             res_data;
  res_t             res_head;

  csm_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .cmd         (in_cmd),
    .index       (in_index),
    .value       (in_value),
    .last_in_row (in_last_in_row),
    .deq         (deq),
    .head_valid  (q_valid),
    .head        (q_item)
  );

  csm_exec u_exec (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .deq      (deq),
    .res_free (res_free),
    .res_push (res_push),
    .res_data (res_data)
  );

  csm_result_queue u_resq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res_data),
    .free    (res_free),
    .pop     (pop),
    .empty   (empty),
    .head    (res_head)
  );

  assign out_row_sum    = res_head.row_sum;
  assign out_row_number = res_head.row_number;

endmodule
